// ----- design/eti_pkg.sv -----
`default_nettype none

package eti_pkg;

  // Q16.16 and Q0.16 reference points
  localparam logic [16:0] QOne        = 17'h10000;
  localparam logic [16:0] QHalf       = 17'h08000;
  localparam logic [63:0] HalfPiQ30   = 64'd1686629713;
  localparam logic [31:0] Deg180      = 32'd11796480;
  localparam logic [31:0] Deg360      = 32'd23592960;

  // Reciprocal of 45 for a 15-bit dividend: floor(z * 23302 / 2^20)
  localparam logic [14:0] Recip45     = 15'd23302;

  typedef enum logic [1:0] {
    MODE_LINEAR = 2'd0,
    MODE_IN     = 2'd1,
    MODE_OUT    = 2'd2,
    MODE_IN_OUT = 2'd3
  } ease_mode_e;

  typedef enum logic [2:0] {
    REG_DURATION  = 3'd0,
    REG_MODE      = 3'd1,
    REG_COUNT     = 3'd2,
    REG_WRAP      = 3'd3,
    REG_START_XY  = 3'd4,
    REG_START_ZW  = 3'd5,
    REG_TARGET_XY = 3'd6,
    REG_TARGET_ZW = 3'd7
  } cfg_reg_e;

endpackage

`default_nettype wire

// ----- design/eased_tween_interpolator.sv -----
`default_nettype none
// Throughput: one beat per cycle unless the output stalls or a register write waits;
// the 16-step restoring divider, the sine ROM read and the component multipliers each
// sit in their own register stages.
// Reset: asynchronous, active low; clears start time, registers (component count to 1)
// and all stage valid bits. Registers are written only while the pipeline is empty.
module eased_tween_interpolator
  import eti_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int TIME_WIDTH       = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // configuration write channel
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [63:0]  cfg_data_i,
  // input stream
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [31:0]  s_axis_tdata_i,   // [31:0] now_time
  input  wire logic [0:0]   s_axis_tuser_i,   // [0] func
  // result stream
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [135:0]      m_axis_tdata_o    // [31:0] out_x, [63:32] out_y,
                                              // [95:64] out_z, [127:96] out_w,
                                              // [128] done_res, [135:129] zero
);

  localparam int CW    = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
  localparam int IW    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int NDIV  = 16;
  localparam int SP    = NDIV + 1;   // phase and index
  localparam int SR    = NDIV + 2;   // ROM read
  localparam int SE    = NDIV + 3;   // easing
  localparam int SM    = NDIV + 4;   // multiply
  localparam int SO    = NDIV + 5;   // output
  localparam int NS    = SO + 1;

  typedef logic [16:0] sine_rom_t [SINE_TABLE_DEPTH+1];

  // Quarter-sine table in Q0.16, Taylor series to the fifteenth power
  function automatic sine_rom_t build_sine();
    sine_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x    = (64'(i) * HalfPiQ30) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      term = ((term * x2) >> 30) / 6;   sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 20;  sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 42;  sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 72;  sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 110; sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 156; sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 210; sum = sum - $signed(term);
      if (sum < 0) sum = 0;
      r = ($unsigned(sum) + 64'd8192) >> 14;
      if (r > 64'(QOne)) r = 64'(QOne);
      rom[i] = r[16:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_sine();

  // ---------------------------------------------------------------- registers
  logic [31:0]      duration_q;
  ease_mode_e       mode_q;
  logic [2:0]       count_q;
  logic             wrap_q;
  logic [63:0]      start_xy_q, start_zw_q, target_xy_q, target_zw_q;
  logic [TIME_WIDTH-1:0] start_time_q;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  // Hold writes until every stage is empty
  assign cfg_ready_o = ~|v_q;

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duration_q  <= '0;
      mode_q      <= MODE_LINEAR;
      count_q     <= 3'd1;
      wrap_q      <= 1'b0;
      start_xy_q  <= '0;
      start_zw_q  <= '0;
      target_xy_q <= '0;
      target_zw_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_DURATION:  duration_q  <= cfg_data_i[31:0];
        REG_MODE:      mode_q      <= ease_mode_e'(cfg_data_i[1:0]);
        REG_COUNT:     count_q     <= cfg_data_i[2:0];
        REG_WRAP:      wrap_q      <= cfg_data_i[0];
        REG_START_XY:  start_xy_q  <= cfg_data_i;
        REG_START_ZW:  start_zw_q  <= cfg_data_i;
        REG_TARGET_XY: target_xy_q <= cfg_data_i;
        REG_TARGET_ZW: target_zw_q <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // ------------------------------------------- per-component deltas from config
  logic signed [31:0] comp_start [4];
  logic signed [31:0] comp_goal  [4];

  assign comp_start[0] = start_xy_q[31:0];
  assign comp_start[1] = start_xy_q[63:32];
  assign comp_start[2] = start_zw_q[31:0];
  assign comp_start[3] = start_zw_q[63:32];
  assign comp_goal[0]  = target_xy_q[31:0];
  assign comp_goal[1]  = target_xy_q[63:32];
  assign comp_goal[2]  = target_zw_q[31:0];
  assign comp_goal[3]  = target_zw_q[63:32];

  logic signed [32:0] w_d0_q  [4];
  logic signed [32:0] w_d1_q  [4];
  logic        [7:0]  w_k_q   [4];
  logic               w_big_q [4];
  logic        [31:0] w_mag_q [4];
  logic               w_neg_q [4];

  // Settle the wrapped delta through the d0, k/big/d1 and mag/neg registers
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      logic        [32:0] abs0;
      logic        [33:0] nsum;
      logic        [29:0] kprod;
      logic signed [33:0] dwide;
      logic signed [33:0] adj;
      w_d0_q[c] <= 33'(comp_goal[c]) - 33'(comp_start[c]);
      abs0  = w_d0_q[c][32] ? 33'(-w_d0_q[c]) : 33'(w_d0_q[c]);
      nsum  = 34'(abs0) + 34'(Deg360) - 34'(Deg180) - 34'd1;
      kprod = 30'(nsum[33:19]) * 30'(Recip45);
      w_k_q[c]   <= kprod[27:20];
      w_big_q[c] <= abs0 > 33'(Deg180);
      w_d1_q[c]  <= w_d0_q[c];
      adj   = $signed(34'(w_k_q[c]) * 34'(Deg360));
      dwide = 34'(w_d1_q[c]);
      if (wrap_q && w_big_q[c]) begin
        dwide = w_d1_q[c][32] ? dwide + adj : dwide - adj;
      end
      w_neg_q[c] <= dwide[33];
      w_mag_q[c] <= dwide[33] ? 32'(-dwide) : 32'(dwide);
    end
  end

  // ---------------------------------------------------------- flow control
  always_comb begin
    en[NS-1] = !v_q[NS-1] || m_axis_tready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  // Hold off input beats while a register write waits
  assign s_axis_tready_o = en[0] && !cfg_valid_i;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= s_axis_tvalid_i && !cfg_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------- stage 0: elapsed
  logic [CW-1:0]         now_ext;
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [CW-1:0]         elapsed_ext;
  logic                  in_accept;
  logic                  in_done;

  assign in_accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign now_ext     = CW'(s_axis_tdata_i);
  assign now_t       = now_ext[TIME_WIDTH-1:0];
  assign elapsed     = s_axis_tuser_i[0] ? now_t - start_time_q : '0;
  assign elapsed_ext = CW'(elapsed);
  assign in_done     = elapsed_ext >= CW'(duration_q);

  // Latch start time on an activate beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_time_q <= '0;
    end else if (in_accept && !s_axis_tuser_i[0]) begin
      start_time_q <= now_t;
    end
  end

  // ---------------------------------------------------------- divider stages
  logic [31:0]     rem_q  [NDIV+1];
  logic [NDIV-1:0] quot_q [NDIV+1];
  logic            done_q [NDIV+1];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      rem_q[0]  <= in_done ? 32'd0 : elapsed_ext[31:0];
      quot_q[0] <= '0;
      done_q[0] <= in_done;
    end
    for (int k = 1; k <= NDIV; k++) begin
      logic [32:0] sh;
      logic        ge;
      sh = {rem_q[k-1], 1'b0};
      ge = sh >= {1'b0, duration_q};
      if (en[k]) begin
        rem_q[k]  <= ge ? 32'(sh - {1'b0, duration_q}) : sh[31:0];
        quot_q[k] <= {quot_q[k-1][NDIV-2:0], ge};
        done_q[k] <= done_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------- phase and index
  logic [16:0]   t_p;
  logic [16:0]   phase;
  logic [31:0]   idx_full;
  logic [16:0]   p_t_q;
  logic [IW-1:0] p_idx_q;
  logic          p_done_q;

  assign t_p = done_q[NDIV] ? QOne : {1'b0, quot_q[NDIV]};

  always_comb begin
    unique case (mode_q)
      MODE_IN:     phase = QOne - t_p;
      MODE_OUT:    phase = t_p;
      MODE_IN_OUT: phase = (t_p <= QHalf) ? QOne - {t_p[15:0], 1'b0}
                                          : {t_p[15:0], 1'b0} - QOne;
      default:     phase = t_p;
    endcase
  end

  assign idx_full = 32'(phase) * 32'(SINE_TABLE_DEPTH) + 32'd32768;

  always_ff @(posedge clk_i) begin
    if (en[SP]) begin
      p_t_q    <= t_p;
      p_idx_q  <= idx_full[16 +: IW];
      p_done_q <= done_q[NDIV];
    end
  end

  // ---------------------------------------------------------- ROM read
  logic [16:0] r_sine_q;
  logic [16:0] r_t_q;
  logic        r_done_q;

  always_ff @(posedge clk_i) begin
    if (en[SR]) begin
      r_sine_q <= SineRom[p_idx_q];
      r_t_q    <= p_t_q;
      r_done_q <= p_done_q;
    end
  end

  // ---------------------------------------------------------- easing
  logic [16:0] ease_val;
  logic [17:0] half_sum;
  logic [16:0] e_ease_q;
  logic        e_done_q;

  always_comb begin
    half_sum = 18'(QOne) - 18'(r_sine_q);
    unique case (mode_q)
      MODE_IN:     ease_val = QOne - r_sine_q;
      MODE_OUT:    ease_val = r_sine_q;
      MODE_IN_OUT: begin
        if (r_t_q > QHalf) half_sum = 18'(QOne) + 18'(r_sine_q);
        ease_val = half_sum[17:1];
      end
      default:     ease_val = r_t_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[SE]) begin
      e_ease_q <= ease_val;
      e_done_q <= r_done_q;
    end
  end

  // ---------------------------------------------------------- multiply
  logic [48:0] m_prod_q [4];
  logic        m_done_q;

  always_ff @(posedge clk_i) begin
    if (en[SM]) begin
      for (int c = 0; c < 4; c++) begin
        m_prod_q[c] <= 49'(w_mag_q[c]) * 49'(e_ease_q);
      end
      m_done_q <= e_done_q;
    end
  end

  // ---------------------------------------------------------- round, add, saturate
  logic [2:0]  used_n;
  logic [31:0] o_comp_q [4];
  logic        o_done_q;

  assign used_n = (count_q > 3'd4) ? 3'd4 : count_q;

  always_ff @(posedge clk_i) begin
    if (en[SO]) begin
      for (int c = 0; c < 4; c++) begin
        logic        [49:0] rnd;
        logic signed [34:0] sum;
        rnd = 50'(m_prod_q[c]) + 50'd32768;
        sum = w_neg_q[c] ? 35'(comp_start[c]) - 35'(rnd[48:16])
                         : 35'(comp_start[c]) + 35'(rnd[48:16]);
        if (3'(c) >= used_n) begin
          o_comp_q[c] <= 32'd0;
        end else if (sum > 35'sh7FFFFFFF) begin
          o_comp_q[c] <= 32'h7FFFFFFF;
        end else if (sum < -35'sh80000000) begin
          o_comp_q[c] <= 32'h80000000;
        end else begin
          o_comp_q[c] <= sum[31:0];
        end
      end
      o_done_q <= m_done_q;
    end
  end

  assign m_axis_tvalid_o = v_q[SO];
  assign m_axis_tdata_o  = {7'd0, o_done_q, o_comp_q[3], o_comp_q[2],
                            o_comp_q[1], o_comp_q[0]};

endmodule

`default_nettype wire

// ----- bench/eased_tween_interpolator_tb.sv -----
`default_nettype none

module eased_tween_interpolator_tb;
  import eti_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TableDepth = 1024;
  localparam int Latency    = 22;

  typedef struct packed {
    logic        done;
    logic [31:0] w;
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } tween_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [63:0]  cfg_data_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [31:0]  s_axis_tdata_i = '0;   // [31:0] now_time
  logic [0:0]   s_axis_tuser_i = '0;   // [0] func
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [135:0] m_axis_tdata_o;        // [31:0] x, [63:32] y, [95:64] z, [127:96] w,
                                       // [128] done

  eased_tween_interpolator dut (.*);

  always #10 clk_i = ~clk_i;

  // shadow of the block's registers and timer
  logic [31:0] dur_q;
  ease_mode_e  mode_q;
  logic [2:0]  count_q;
  logic        wrap_q;
  logic [63:0] start_xy_q, start_zw_q, target_xy_q, target_zw_q;
  logic [31:0] start_time_q;

  longint unsigned sine_rom [0:TableDepth];
  tween_res_t      expected_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int done_seen = 0;
  int rdy_stall_pct = 20;

  function automatic longint unsigned sine_at(longint unsigned p);
    longint unsigned idx;
    if (p > 65536) p = 65536;
    idx = (p * TableDepth + 32768) >> 16;
    return sine_rom[idx];
  endfunction

  function automatic longint unsigned eased(longint unsigned t);
    case (mode_q)
      MODE_IN:  return 65536 - sine_at(65536 - t);
      MODE_OUT: return sine_at(t);
      MODE_IN_OUT:
        if (t <= 32768) return (65536 - sine_at(65536 - 2 * t)) >> 1;
        else return (65536 + sine_at(2 * t - 65536)) >> 1;
      default:  return t;
    endcase
  endfunction

  function automatic logic [31:0] tween_component(logic [31:0] s32, logic [31:0] g32,
                                                  longint unsigned e);
    longint s, d, outv;
    longint unsigned mag;
    s = longint'($signed(s32));
    d = longint'($signed(g32)) - s;
    if (wrap_q) begin
      if (d > 11796480) d -= ((d - 11796480 + 23592959) / 23592960) * 23592960;
      else if (d < -11796480) d += ((-d - 11796480 + 23592959) / 23592960) * 23592960;
    end
    mag = (d < 0) ? -d : d;
    mag = (mag * e + 32768) >> 16;
    outv = (d < 0) ? s - longint'(mag) : s + longint'(mag);
    if (outv > 64'sd2147483647) outv = 64'sd2147483647;
    if (outv < -64'sd2147483648) outv = -64'sd2147483648;
    return outv[31:0];
  endfunction

  function automatic tween_res_t predict_tween(logic func, logic [31:0] now);
    tween_res_t r;
    logic [31:0] elapsed;
    longint unsigned t, e;
    int cnt;
    logic [31:0] sv[4], gv[4];
    if (!func) start_time_q = now;
    elapsed = now - start_time_q;
    r.done = (elapsed >= dur_q);
    t = r.done ? 65536 : ((64'(elapsed) << 16) / dur_q);
    e = eased(t);
    cnt = (count_q > 4) ? 4 : count_q;
    sv = '{start_xy_q[31:0], start_xy_q[63:32], start_zw_q[31:0], start_zw_q[63:32]};
    gv = '{target_xy_q[31:0], target_xy_q[63:32], target_zw_q[31:0], target_zw_q[63:32]};
    r.x = (cnt > 0) ? tween_component(sv[0], gv[0], e) : '0;
    r.y = (cnt > 1) ? tween_component(sv[1], gv[1], e) : '0;
    r.z = (cnt > 2) ? tween_component(sv[2], gv[2], e) : '0;
    r.w = (cnt > 3) ? tween_component(sv[3], gv[3], e) : '0;
    return r;
  endfunction

  // build the quarter-sine table with truncated Taylor terms
  initial begin
    longint unsigned xa, x2, term, r;
    longint sum;
    for (int i = 0; i <= TableDepth; i++) begin
      xa = (64'(i) * 64'd1686629713) / TableDepth;
      x2 = (xa * xa) >> 30;
      term = xa;
      sum = xa;
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
        if (k % 2) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      r = ($unsigned(sum) + 8192) >> 14;
      sine_rom[i] = (r > 65536) ? 65536 : r;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // check each result beat against the oldest expectation
  always @(posedge clk_i) begin
    tween_res_t got, exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[128:0];
      results_seen++;
      if (got.done) done_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r || m_axis_tdata_o[135:129] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d exp x=%h y=%h z=%h w=%h d=%b got x=%h y=%h z=%h w=%h d=%b",
                     results_seen, exp_r.x, exp_r.y, exp_r.z, exp_r.w, exp_r.done,
                     got.x, got.y, got.z, got.w, got.done);
        end
      end
    end
  end

  // drive the result-side stall pattern
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= rdy_stall_pct);
  end

  // valid stays high into the next beat when no gap follows
  task automatic send_item(logic func, logic [31:0] now);
    int gap;
    gap = gap_len();
    cfg_valid_i <= 1'b0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= func;
    s_axis_tdata_i <= now;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_q.push_back(predict_tween(func, now));
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [63:0] val);
    s_axis_tvalid_i <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_DURATION:  dur_q = val[31:0];
      REG_MODE:      mode_q = ease_mode_e'(val[1:0]);
      REG_COUNT:     count_q = val[2:0];
      REG_WRAP:      wrap_q = val[0];
      REG_START_XY:  start_xy_q = val;
      REG_START_ZW:  start_zw_q = val;
      REG_TARGET_XY: target_xy_q = val;
      default:       target_zw_q = val;
    endcase
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(4))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h01ff_ffff) - 32'h0100_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic load_ends();
    write_reg(REG_START_XY, {rand_q16(), rand_q16()});
    write_reg(REG_START_ZW, {rand_q16(), rand_q16()});
    write_reg(REG_TARGET_XY, {rand_q16(), rand_q16()});
    write_reg(REG_TARGET_ZW, {rand_q16(), rand_q16()});
  endtask

  // reset defaults, then field extremes, every curve and the corner cases
  task automatic test_directed();
    send_item(1'b1, 32'd5);                      // zero duration at reset
    write_reg(REG_COUNT, 64'd4);
    write_reg(REG_START_XY, {32'h8000_0000, 32'h7fff_ffff});
    write_reg(REG_TARGET_XY, {32'h7fff_ffff, 32'h8000_0000});
    write_reg(REG_START_ZW, {32'h0000_0000, 32'hfff0_0000});
    write_reg(REG_TARGET_ZW, {32'hffff_ffff, 32'h0010_0000});
    write_reg(REG_DURATION, 64'd1000);
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_MODE, 64'(m));
      send_item(1'b0, 32'hffff_fe00);            // activate near the wrap point
      send_item(1'b1, 32'hffff_ff00);
      send_item(1'b1, 32'h0000_00e8);            // timer wrapped past zero
      send_item(1'b1, 32'hffff_fdff);            // now before start
      drain();
    end
    write_reg(REG_DURATION, 64'hffff_ffff);
    send_item(1'b0, 32'd0);
    send_item(1'b1, 32'hffff_fffe);
    send_item(1'b1, 32'hffff_ffff);
    drain();
    write_reg(REG_WRAP, 64'd1);
    write_reg(REG_COUNT, 64'd0);
    send_item(1'b1, 32'd7);                      // no components in use
    drain();
    write_reg(REG_COUNT, 64'd7);                 // clamps to four
    write_reg(REG_START_XY, {32'hfec8_0000, 32'h00b4_0000});
    write_reg(REG_TARGET_XY, {32'h0136_0000, 32'hff4c_0000});
    send_item(1'b1, 32'h7fff_ffff);
    drain();
  endtask

  // random configurations with bursts of samples after each activate
  task automatic test_random(int n_items);
    int sent;
    logic [31:0] t0;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(5))
        0: write_reg(REG_DURATION, 64'd0);
        1: write_reg(REG_DURATION, 64'hffff_ffff);
        2: write_reg(REG_DURATION, 64'($urandom_range(1, 8)));
        default: write_reg(REG_DURATION, 64'($urandom_range(1, 5000)));
      endcase
      write_reg(REG_MODE, 64'($urandom_range(3)));
      write_reg(REG_COUNT, 64'($urandom_range(7)));
      write_reg(REG_WRAP, 64'($urandom_range(1)));
      if ($urandom_range(3) == 0) begin
        write_reg(REG_START_XY, rand64());
        write_reg(REG_TARGET_ZW, rand64());
      end else begin
        load_ends();
      end
      rdy_stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 60);
      t0 = $urandom();
      send_item(1'b0, t0);
      sent++;
      for (int k = 0; k < 60 && sent < n_items; k++) begin
        if ($urandom_range(15) == 0) begin
          t0 = $urandom();
          send_item(1'b0, t0);
        end else if ($urandom_range(9) == 0) begin
          send_item(1'b1, $urandom());
        end else begin
          send_item(1'b1, t0 + $urandom_range(0, dur_q > 6000 ? 6000 : dur_q + 2));
        end
        sent++;
      end
      drain();
    end
  endtask

  initial begin
    dur_q = '0; mode_q = MODE_LINEAR; count_q = 3'd1; wrap_q = 1'b0;
    start_xy_q = '0; start_zw_q = '0; target_xy_q = '0; target_zw_q = '0;
    start_time_q = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(1400);
    $display("Covered %0d results (%0d with done set) over all curves, counts and wrap modes.",
             results_seen, done_seen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Mismatches: %0d, missing results: %0d", mismatches, expected_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout");
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
